@@ src/pmpu_pkg.sv @@
// Shared types, constants and register codes of the pixel mask pack/unpack block.
package pmpu_pkg;

  localparam int unsigned MAX_CHANNELS   = 4;
  localparam int unsigned MAX_WORD_BYTES = 4;
  localparam int unsigned QUEUE_DEPTH    = 2;

  // Configuration register indexes.
  localparam logic [2:0] REG_LITTLE_ENDIAN   = 3'd0;
  localparam logic [2:0] REG_BYTES_PER_PIXEL = 3'd1;
  localparam logic [2:0] REG_CHANNELS_IN_USE = 3'd2;
  localparam logic [2:0] REG_MASK_RED        = 3'd3;
  localparam logic [2:0] REG_MASK_GREEN      = 3'd4;
  localparam logic [2:0] REG_MASK_BLUE       = 3'd5;
  localparam logic [2:0] REG_MASK_ALPHA      = 3'd6;

  // Input operation codes and result kinds.
  localparam logic MODE_PACK   = 1'b0;
  localparam logic MODE_UNPACK = 1'b1;
  localparam logic KIND_BYTE   = 1'b0;
  localparam logic KIND_PIXEL  = 1'b1;

  typedef struct packed {
    logic       mode;
    logic [7:0] channel_0;
    logic [7:0] channel_1;
    logic [7:0] channel_2;
    logic [7:0] channel_3;
    logic [7:0] byte_in;
    logic       end_of_buffer;
  } in_word_t;

  typedef struct packed {
    logic       result_kind;
    logic [7:0] byte_out;
    logic [7:0] chan_out_0;
    logic [7:0] chan_out_1;
    logic [7:0] chan_out_2;
    logic [7:0] chan_out_3;
    logic       last_of_run;
    logic       buffer_end;
  } out_word_t;

  typedef struct packed {
    logic                                little_endian;
    logic [2:0]                          bytes_per_pixel;
    logic [2:0]                          channels_in_use;
    logic [MAX_CHANNELS-1:0][31:0]       mask;
  } cfg_t;

  // One job for the back end: a packed word to send as bytes, or an
  // unpacked pixel held as four channel bytes (channel 0 in the low byte).
  typedef struct packed {
    logic        kind;
    logic        little_endian;
    logic [1:0]  nbytes_m1;
    logic        eob;
    logic [31:0] data;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

@@ src/pmpu_front.sv @@
// Front end: accepts words, packs pixels or collects unpack bytes, queues jobs.
module pmpu_front (
  input  logic               clk,
  input  logic               rst_n,
  input  pmpu_pkg::cfg_t     cfg,
  input  logic               in_valid,
  input  pmpu_pkg::in_word_t in_data,
  input  logic               accept,
  output logic               push,
  output pmpu_pkg::entry_t   push_data
);
  import pmpu_pkg::*;

  // Position of the highest set bit, zero for an empty mask.
  function automatic logic [4:0] top_bit(input logic [31:0] v);
    logic [31:0] x;
    logic [4:0]  p;
    x = v;
    p = '0;
    if (|(x & 32'hffff0000)) begin
      x = x >> 16;
      p = p + 5'd16;
    end
    if (|(x & 32'h0000ff00)) begin
      x = x >> 8;
      p = p + 5'd8;
    end
    if (|(x & 32'h000000f0)) begin
      x = x >> 4;
      p = p + 5'd4;
    end
    if (|(x & 32'h0000000c)) begin
      x = x >> 2;
      p = p + 5'd2;
    end
    if (|(x & 32'h00000002)) begin
      p = p + 5'd1;
    end
    return p;
  endfunction

  logic [31:0] acc_r, acc_nxt;
  logic [1:0]  cnt_r, cnt_nxt;

  logic [2:0]  nchan;
  logic [1:0]  nbytes_m1;
  logic [MAX_CHANNELS-1:0][7:0] chan_in;
  logic [MAX_CHANNELS-1:0][7:0] chan_unp;
  logic [31:0] pack_word;
  logic [31:0] acc_new;
  logic [31:0] unp_word;
  logic        complete;

  always_comb begin
    if (cfg.channels_in_use == 3'd0) begin
      nchan = 3'd1;
    end else if (cfg.channels_in_use > 3'(MAX_CHANNELS)) begin
      nchan = 3'(MAX_CHANNELS);
    end else begin
      nchan = cfg.channels_in_use;
    end
    if (cfg.bytes_per_pixel == 3'd0) begin
      nbytes_m1 = 2'd0;
    end else if (cfg.bytes_per_pixel > 3'(MAX_WORD_BYTES)) begin
      nbytes_m1 = 2'(MAX_WORD_BYTES - 1);
    end else begin
      nbytes_m1 = 2'(cfg.bytes_per_pixel - 3'd1);
    end
  end

  assign chan_in[0] = in_data.channel_0;
  assign chan_in[1] = in_data.channel_1;
  assign chan_in[2] = in_data.channel_2;
  assign chan_in[3] = in_data.channel_3;

  // New accumulator value once this byte is taken in.
  always_comb begin
    if (cfg.little_endian) begin
      acc_new = acc_r | ({24'd0, in_data.byte_in} << {cnt_r, 3'b000});
    end else begin
      acc_new = {acc_r[23:0], in_data.byte_in};
    end
    complete = (cnt_r >= nbytes_m1);
    case (nbytes_m1)
      2'd0:    unp_word = acc_new & 32'h000000ff;
      2'd1:    unp_word = acc_new & 32'h0000ffff;
      2'd2:    unp_word = acc_new & 32'h00ffffff;
      default: unp_word = acc_new;
    endcase
  end

  // Per-channel alignment: input bit 7 sits on the mask's top bit.
  always_comb begin
    logic [4:0]  hb;
    logic [31:0] al;
    logic [31:0] t;
    logic [31:0] ex;
    pack_word = '0;
    chan_unp  = '0;
    for (int i = 0; i < MAX_CHANNELS; i++) begin
      hb = top_bit(cfg.mask[i]);
      if (hb >= 5'd7) begin
        al = {24'd0, chan_in[i]} << (hb - 5'd7);
      end else begin
        al = {24'd0, chan_in[i]} >> (5'd7 - hb);
      end
      t = unp_word & cfg.mask[i];
      if (hb >= 5'd7) begin
        ex = t >> (hb - 5'd7);
      end else begin
        ex = t << (5'd7 - hb);
      end
      if (3'(i) < nchan) begin
        pack_word   = pack_word | (al & cfg.mask[i]);
        chan_unp[i] = ex[7:0];
      end
    end
  end

  always_comb begin
    push_data.little_endian = cfg.little_endian;
    push_data.nbytes_m1     = nbytes_m1;
    push_data.eob           = in_data.end_of_buffer;
    if (in_data.mode == MODE_PACK) begin
      push_data.kind = KIND_BYTE;
      push_data.data = pack_word;
    end else begin
      push_data.kind = KIND_PIXEL;
      push_data.data = chan_unp;
    end
  end

  assign push = accept && ((in_data.mode == MODE_PACK) || complete);

  always_comb begin
    acc_nxt = acc_r;
    cnt_nxt = cnt_r;
    if (accept && (in_data.mode == MODE_UNPACK)) begin
      if (complete) begin
        acc_nxt = '0;
        cnt_nxt = '0;
      end else begin
        acc_nxt = acc_new;
        cnt_nxt = cnt_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
      cnt_r <= '0;
    end else begin
      acc_r <= acc_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // A byte taken into a partial word advances the byte count.
  a_cnt_below_size: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_valid && (in_data.mode == MODE_UNPACK) && !complete)
      |=> (cnt_r != 2'd0))
    else $error("front: byte count did not advance on a partial word");

endmodule

@@ src/pmpu_queue.sv @@
// Job queue between the front end and the back end.
module pmpu_queue #(
  parameter int unsigned DEPTH = pmpu_pkg::QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  pmpu_pkg::entry_t    push_data,
  input  logic                pop,
  output pmpu_pkg::entry_t    head,
  output pmpu_pkg::q_status_t status
);
  import pmpu_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  entry_t             mem_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;

  assign status.full  = (count_r == CNT_W'(DEPTH));
  assign status.empty = (count_r == '0);
  assign head         = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && status.full))
    else $error("queue: push while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(pop && status.empty))
    else $error("queue: pop while empty");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r <= CNT_W'(DEPTH)))
    else $error("queue: occupancy beyond depth");

endmodule

@@ src/pmpu_back.sv @@
// Back end: turns queued jobs into result words through the output register.
module pmpu_back (
  input  logic                clk,
  input  logic                rst_n,
  input  pmpu_pkg::entry_t    head,
  input  pmpu_pkg::q_status_t status,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_stall,
  output pmpu_pkg::out_word_t out_data
);
  import pmpu_pkg::*;

  logic      out_valid_r, out_valid_nxt;
  out_word_t out_word_r, out_word_nxt;
  logic [1:0] idx_r, idx_nxt;
  logic [1:0] sel;
  logic       load;
  logic       last;

  assign load = !status.empty && (!out_valid_r || !out_stall);
  assign last = (head.kind == KIND_PIXEL) || (idx_r == head.nbytes_m1);
  assign pop  = load && last;
  assign sel  = head.little_endian ? idx_r : (head.nbytes_m1 - idx_r);

  always_comb begin
    out_word_nxt             = '0;
    out_word_nxt.result_kind = head.kind;
    out_word_nxt.last_of_run = last;
    out_word_nxt.buffer_end  = last & head.eob;
    if (head.kind == KIND_BYTE) begin
      out_word_nxt.byte_out = head.data[{sel, 3'b000} +: 8];
    end else begin
      out_word_nxt.chan_out_0 = head.data[7:0];
      out_word_nxt.chan_out_1 = head.data[15:8];
      out_word_nxt.chan_out_2 = head.data[23:16];
      out_word_nxt.chan_out_3 = head.data[31:24];
    end
  end

  always_comb begin
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r;
    if (load) begin
      idx_nxt       = last ? 2'd0 : idx_r + 2'd1;
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_word_r <= out_word_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      idx_r       <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      idx_r       <= idx_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_word_r;

  // A job being sent byte by byte stays at the head of the queue.
  a_mid_job_head: assert property (@(posedge clk) disable iff (!rst_n)
    (idx_r != 2'd0) |-> !status.empty)
    else $error("back: job left the queue before its last byte");

  // A pixel result is always the only result of its word.
  a_pixel_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_word_r.result_kind == KIND_PIXEL)) |-> out_word_r.last_of_run)
    else $error("back: pixel result not marked last");

endmodule

@@ src/pixel_mask_pack_unpack.sv @@
// Top level of the pixel mask pack/unpack block.
//
// The block converts pixels between up to four 8-bit channels and packed
// words of one to four bytes, placed by per-channel bit masks. Each input
// word either packs one pixel (it then yields bytes_per_pixel byte results,
// in the configured byte order) or carries one byte of a packed stream (a
// pixel result comes out when a whole word has been collected).
// Both channels use valid and stall; a word moves at an edge with valid high
// and stall low. The configuration port writes one register per enabled
// cycle and must be used only while the block is idle.
// An accepted word passes through the job queue into the output register.
// The front end takes one input word per cycle while its job queue has
// room; the back end sends one result per cycle while the receiver does not
// stall, so a pack word yields one to four byte results and an unpack byte
// at most one. The output register is the rate limit for packing.
// Reset (synchronous, active low) empties the queue and output register,
// clears the byte accumulator and loads the default layout: little-endian,
// three bytes, three channels, masks 0xff0000, 0xff00, 0xff and zero.
// When the receiver stalls, the current result holds, the queue fills and
// in_stall rises once it is full; nothing is dropped.
module pixel_mask_pack_unpack #(
  parameter int unsigned Q_DEPTH = pmpu_pkg::QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  pmpu_pkg::in_word_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output pmpu_pkg::out_word_t out_data,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [31:0]         cfg_wdata
);
  import pmpu_pkg::*;

  cfg_t      cfg_r, cfg_nxt;
  q_status_t q_status;
  entry_t    push_data;
  entry_t    head;
  logic      accept;
  logic      push;
  logic      pop;

  // Configuration registers. Writes to the unused index are ignored.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_LITTLE_ENDIAN:   cfg_nxt.little_endian   = cfg_wdata[0];
        REG_BYTES_PER_PIXEL: cfg_nxt.bytes_per_pixel = cfg_wdata[2:0];
        REG_CHANNELS_IN_USE: cfg_nxt.channels_in_use = cfg_wdata[2:0];
        REG_MASK_RED:        cfg_nxt.mask[0]         = cfg_wdata;
        REG_MASK_GREEN:      cfg_nxt.mask[1]         = cfg_wdata;
        REG_MASK_BLUE:       cfg_nxt.mask[2]         = cfg_wdata;
        REG_MASK_ALPHA:      cfg_nxt.mask[3]         = cfg_wdata;
        default:             cfg_nxt                 = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.little_endian   <= 1'b1;
      cfg_r.bytes_per_pixel <= 3'd3;
      cfg_r.channels_in_use <= 3'd3;
      cfg_r.mask[0]         <= 32'h00ff0000;
      cfg_r.mask[1]         <= 32'h0000ff00;
      cfg_r.mask[2]         <= 32'h000000ff;
      cfg_r.mask[3]         <= 32'h00000000;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // The front end is held off only by a full queue, never by the output side
  // directly, so a waiting result does not block new input.
  assign in_stall = q_status.full;
  assign accept   = in_valid && !q_status.full;

  pmpu_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .accept    (accept),
    .push      (push),
    .push_data (push_data)
  );

  pmpu_queue #(
    .DEPTH (Q_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .status    (q_status)
  );

  pmpu_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .status    (q_status),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
